### rtl/iminh_pkg.sv
// ----------------------------------------------------------------------------
// iminh_pkg
// Types, codes and constants shared by the indexed min-heap open list.
// ----------------------------------------------------------------------------
`default_nettype none

package iminh_pkg;

    localparam int ID_W    = 12;
    localparam int ID_SPACE = 4096;
    localparam int G_W     = 31;
    localparam int F_W     = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_POP_EMPTY = 2'd2;

    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_OPEN   = 2'd1;
    localparam logic [1:0] MARK_CLOSED = 2'd2;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] item_id;
        logic [G_W-1:0]  g_cost;
        logic [G_W-1:0]  h_cost;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0] out_id;
        logic [G_W-1:0]  out_g;
        logic [F_W-1:0]  out_f;
        logic            popped_valid;
        logic            heap_empty;
        logic [1:0]      status;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [G_W-1:0]  g;
        logic [F_W-1:0]  f;
    } t_entry;

    typedef enum logic [3:0] {
        C_NONE,
        C_CLR,
        C_ACCEPT,
        C_OPEN_EXIST,
        C_APPEND,
        C_REFUSE,
        C_EMPTY,
        C_UP_RD,
        C_UP_MOVE,
        C_POP_RD,
        C_POP_TAKE,
        C_POP_LAST,
        C_DN_RD1,
        C_DN_RD2,
        C_DN_MOVE,
        C_PLACE
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic cnt_one;
        logic open_hit;
        logic slot_zero;
        logic up_less;
        logic c1_out;
        logic pick_less;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_OP_CLR,
        S_IDLE,
        S_LOOK,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_TAKE,
        S_POP_LAST,
        S_DN_RD1,
        S_DN_RD2,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/iminh_dp.sv
// ----------------------------------------------------------------------------
// iminh_dp
// Heap, position and mark memories with the sift registers and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module iminh_dp
    import iminh_pkg::*;
#(
    parameter int MAX_ITEMS = 4096
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_in_word  i_in_data,
    input  wire logic      i_done,
    input  wire logic      i_out_ready,
    output t_dp_stat       o_stat,
    output logic           o_out_valid,
    output t_out_word      o_out_data
);

    localparam int HW = $clog2(MAX_ITEMS);
    localparam int CW = HW + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

    t_entry          r_heap [MAX_ITEMS];
    logic [1:0]      r_mark [ID_SPACE];
    logic [HW-1:0]   r_pos  [ID_SPACE];

    t_entry          r_heap_q;
    logic [1:0]      r_mark_q;
    logic [HW-1:0]   r_pos_q;
    t_entry          r_cur;
    t_entry          r_ch;
    logic            r_has_c2;
    logic [HW-1:0]   r_slot;
    logic [CW-1:0]   r_cnt;
    logic [ID_W-1:0] r_clr_addr;
    t_out_word       r_res;
    t_out_word       r_out;
    logic            r_out_valid;

    logic [HW-1:0]   parent;
    logic [CW-1:0]   c1;
    logic [CW:0]     c2;
    logic [CW-1:0]   cnt_m1;
    logic            pick_c2;
    t_entry          pick;
    logic [HW-1:0]   pick_idx;

    logic            heap_we;
    logic [HW-1:0]   heap_waddr;
    t_entry          heap_wdata;
    logic [HW-1:0]   heap_raddr;
    logic            pos_we;
    logic [ID_W-1:0] pos_waddr;
    logic            mark_we;
    logic [ID_W-1:0] mark_waddr;
    logic [1:0]      mark_wdata;

    assign parent   = (r_slot - HW'(1)) >> 1;
    assign c1       = {r_slot, 1'b1};
    assign c2       = {1'b0, c1} + (CW+1)'(1);
    assign cnt_m1   = r_cnt - CW'(1);
    // equal keys go to the second child
    assign pick_c2  = r_has_c2 && !(r_ch.f < r_heap_q.f);
    assign pick     = pick_c2 ? r_heap_q : r_ch;
    assign pick_idx = pick_c2 ? c2[HW-1:0] : c1[HW-1:0];

    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = r_slot;
        heap_wdata = r_cur;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = r_cur.id;
        mark_we    = 1'b0;
        mark_waddr = r_cur.id;
        mark_wdata = MARK_OPEN;
        case (i_cmd)
            C_CLR: begin
                mark_we    = 1'b1;
                mark_waddr = r_clr_addr;
                mark_wdata = MARK_NONE;
            end
            C_APPEND: begin
                mark_we = 1'b1;
            end
            C_UP_RD: begin
                heap_raddr = parent;
            end
            C_UP_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = r_heap_q;
                pos_we     = 1'b1;
                pos_waddr  = r_heap_q.id;
            end
            C_POP_TAKE: begin
                mark_we    = 1'b1;
                mark_waddr = r_heap_q.id;
                mark_wdata = MARK_CLOSED;
                heap_raddr = cnt_m1[HW-1:0];
            end
            C_DN_RD1: begin
                heap_raddr = c1[HW-1:0];
            end
            C_DN_RD2: begin
                heap_raddr = c2[HW-1:0];
            end
            C_DN_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = pick;
                pos_we     = 1'b1;
                pos_waddr  = pick.id;
            end
            C_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            r_heap[heap_waddr] <= heap_wdata;
        end
        r_heap_q <= r_heap[heap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos[pos_waddr] <= r_slot;
        end
        r_pos_q <= r_pos[i_in_data.item_id];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark[mark_waddr] <= mark_wdata;
        end
        r_mark_q <= r_mark[i_in_data.item_id];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_ACCEPT: begin
                r_cur.id <= i_in_data.item_id;
                r_cur.g  <= i_in_data.g_cost;
                r_cur.f  <= {1'b0, i_in_data.g_cost} + {1'b0, i_in_data.h_cost};
                r_res    <= '0;
            end
            C_OPEN_EXIST: r_slot <= r_pos_q;
            C_APPEND:     r_slot <= r_cnt[HW-1:0];
            C_REFUSE:     r_res.status <= STS_FULL;
            C_EMPTY:      r_res.status <= STS_POP_EMPTY;
            C_UP_MOVE:    r_slot <= parent;
            C_POP_TAKE: begin
                r_res.out_id       <= r_heap_q.id;
                r_res.out_g        <= r_heap_q.g;
                r_res.out_f        <= r_heap_q.f;
                r_res.popped_valid <= 1'b1;
            end
            C_POP_LAST: begin
                r_cur  <= r_heap_q;
                r_slot <= '0;
            end
            C_DN_RD2: begin
                r_ch     <= r_heap_q;
                r_has_c2 <= c2 < {1'b0, r_cnt};
            end
            C_DN_MOVE:    r_slot <= pick_idx;
            default: begin
            end
        endcase
        if (i_done && o_stat.out_free) begin
            r_out <= {r_res.out_id, r_res.out_g, r_res.out_f, r_res.popped_valid,
                      (r_cnt == '0), r_res.status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd)
                C_CLR: begin
                    r_cnt      <= '0;
                    r_clr_addr <= r_clr_addr + ID_W'(1);
                end
                C_APPEND:   r_cnt <= r_cnt + CW'(1);
                C_POP_TAKE: r_cnt <= cnt_m1;
                default: begin
                end
            endcase
            if (i_done && o_stat.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.cnt_full  = (r_cnt >= CNT_MAX);
    assign o_stat.cnt_one   = (r_cnt == CW'(1));
    assign o_stat.open_hit  = (r_mark_q == MARK_OPEN) && ({1'b0, r_pos_q} < r_cnt);
    assign o_stat.slot_zero = (r_slot == '0);
    assign o_stat.up_less   = r_cur.f < r_heap_q.f;
    assign o_stat.c1_out    = c1 >= r_cnt;
    assign o_stat.pick_less = pick.f < r_cur.f;
    assign o_stat.clr_last  = &r_clr_addr;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### rtl/iminh_ctrl.sv
// ----------------------------------------------------------------------------
// iminh_ctrl
// Sequencer for insert, decrease-key, pop and clear over the heap datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module iminh_ctrl
    import iminh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic [1:0] i_opcode,
    input  wire t_dp_stat i_stat,
    output logic       o_in_ready,
    output logic       o_done,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = C_NONE;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            S_RST_CLR, S_OP_CLR: begin
                o_cmd = C_CLR;
                if (i_stat.clr_last) begin
                    n_state = (r_state == S_OP_CLR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = C_ACCEPT;
                    case (i_opcode)
                        OP_INSERT: n_state = S_LOOK;
                        OP_POP:    n_state = S_POP_RD;
                        OP_CLEAR:  n_state = S_OP_CLR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK: begin
                if (i_stat.open_hit) begin
                    o_cmd   = C_OPEN_EXIST;
                    n_state = S_UP_RD;
                end else if (i_stat.cnt_full) begin
                    o_cmd   = C_REFUSE;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = C_APPEND;
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (i_stat.slot_zero) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd   = C_UP_RD;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_cmd   = C_UP_MOVE;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_POP_RD: begin
                if (i_stat.cnt_zero) begin
                    o_cmd   = C_EMPTY;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = C_POP_RD;
                    n_state = S_POP_TAKE;
                end
            end
            S_POP_TAKE: begin
                o_cmd   = C_POP_TAKE;
                n_state = i_stat.cnt_one ? S_DONE : S_POP_LAST;
            end
            S_POP_LAST: begin
                o_cmd   = C_POP_LAST;
                n_state = S_DN_RD1;
            end
            S_DN_RD1: begin
                if (i_stat.c1_out) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd   = C_DN_RD1;
                    n_state = S_DN_RD2;
                end
            end
            S_DN_RD2: begin
                o_cmd   = C_DN_RD2;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.pick_less) begin
                    o_cmd   = C_DN_MOVE;
                    n_state = S_DN_RD1;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd   = C_PLACE;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/indexed_min_heap_open_list.sv
// insert/decrease-key: the entry climbs one level per compare step until it stops below its parent or reaches the root
// pop: the last entry moves to the root and sinks to the smaller child until none is smaller or it is a leaf
// clear: one mark entry cleared per cycle; opcode three goes straight to its result word
// one word in flight at a time; the next word is taken while a result waits
// after reset the whole mark memory is swept before the first word is taken
// ----------------------------------------------------------------------------
// indexed_min_heap_open_list
// Open list of a best-first search: indexed binary min-heap on f = g + h.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_open_list
    import iminh_pkg::*;
#(
    parameter int MAX_ITEMS = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_word i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_word o_out_data
);

    t_cmd     cmd;
    t_dp_stat stat;
    logic     done;

    iminh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_done     (done),
        .o_cmd      (cmd)
    );

    iminh_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_done      (done),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.popped_valid |-> o_out_data.status == STS_OK)
        else $error("popped word carries an error status");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STS_POP_EMPTY |-> o_out_data.heap_empty)
        else $error("pop on empty left entries in the heap");

    a_f_ge_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.popped_valid |->
            o_out_data.out_f >= {1'b0, o_out_data.out_g})
        else $error("popped f below its g");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd == C_ACCEPT |=> !o_in_ready)
        else $error("word taken while the previous one is still in work");

endmodule

`default_nettype wire
